>>> src/depth_to_point_deprojection_macros.svh
// Assertion macros for the depth-to-point deprojection block.
// Included by the top level; needs no package.
`ifndef DEPTH_TO_POINT_DEPROJECTION_MACROS_SVH
`define DEPTH_TO_POINT_DEPROJECTION_MACROS_SVH

`ifndef ASSERT_OFF
// Implication checked on every rising edge outside reset.
`define D2P_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define D2P_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define D2P_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define D2P_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

>>> src/d2p_pkg.sv
// Shared types and constants of the depth-to-point deprojection block.
// Used by every module; depends on nothing.
package d2p_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned MAX_STEP      = 16;

  localparam int unsigned STEP_W  = 5;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned CTR_W   = 16;
  localparam int unsigned INVF_W  = 24;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 32;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_STEP   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CIDX_W-1:0] REG_CX     = 3'd3;
  localparam logic [CIDX_W-1:0] REG_CY     = 3'd4;
  localparam logic [CIDX_W-1:0] REG_IFX    = 3'd5;
  localparam logic [CIDX_W-1:0] REG_IFY    = 3'd6;

  localparam logic [DEPTH_W-1:0] DEPTH_BAD_HI = 16'hFFFF;

  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [CTR_W-1:0]   center_x;
    logic [CTR_W-1:0]   center_y;
    logic [INVF_W-1:0]  inv_focal_x;
    logic [INVF_W-1:0]  inv_focal_y;
  } cfg_t;

  // One kept pixel on its way from front to back
  typedef struct packed {
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic [DEPTH_W-1:0] depth;
    logic               last;
  } item_t;

endpackage

>>> src/depth_to_point_deprojection.sv
// Top level of the depth-to-point deprojection block: registers, front, queue, back.
// Depends on d2p_pkg, d2p_front, d2p_queue, d2p_back and the assertion macros header.
//
//  channel   handshake                payload
//  --------  -----------------------  ----------------------------------------------
//  in        in_valid_i / in_ready_o  depth_i, first_of_frame_i
//  out       out_valid_o/out_ready_i  x_pos_o, y_pos_o, z_depth_o, point_valid_o,
//                                     last_point_o
//  cfg       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One pixel request is taken per cycle while in_ready_o is high; a kept pixel that
// leaves the queue passes offset, two multiplies and round/saturate into the output
// register. After reset and after any write of step, width or height, the grid limit
// unit steps through the size bits, one per cycle, with in_ready_o low. The four-entry
// queue lets the raster counters keep going while the output stalls; in_ready_o drops
// on a full queue or a busy limit unit. Config requests are always taken.
`include "depth_to_point_deprojection_macros.svh"

module depth_to_point_deprojection (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [d2p_pkg::CIDX_W-1:0]         cfg_index_i,
  input  logic [d2p_pkg::CDATA_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [d2p_pkg::DEPTH_W-1:0]        depth_i,
  input  logic                               first_of_frame_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [d2p_pkg::COORD_W-1:0] x_pos_o,
  output logic signed [d2p_pkg::COORD_W-1:0] y_pos_o,
  output logic [d2p_pkg::DEPTH_W-1:0]        z_depth_o,
  output logic                               point_valid_o,
  output logic                               last_point_o
);

  d2p_pkg::cfg_t  cfg_q;
  logic           cfg_we, geo_start;
  logic           push, q_full, pop, q_valid;
  d2p_pkg::item_t push_item, pop_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  // any geometry write restarts the grid limit computation
  assign geo_start   = cfg_we && (cfg_index_i == d2p_pkg::REG_STEP ||
                                  cfg_index_i == d2p_pkg::REG_WIDTH ||
                                  cfg_index_i == d2p_pkg::REG_HEIGHT);

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step        <= d2p_pkg::STEP_W'(3);
      cfg_q.width       <= d2p_pkg::DIM_W'(640);
      cfg_q.height      <= d2p_pkg::DIM_W'(480);
      cfg_q.center_x    <= d2p_pkg::CTR_W'(5120);
      cfg_q.center_y    <= d2p_pkg::CTR_W'(3840);
      cfg_q.inv_focal_x <= d2p_pkg::INVF_W'(27962);
      cfg_q.inv_focal_y <= d2p_pkg::INVF_W'(27962);
    end else if (cfg_we) begin
      case (cfg_index_i)
        d2p_pkg::REG_STEP:   cfg_q.step        <= cfg_data_i[d2p_pkg::STEP_W-1:0];
        d2p_pkg::REG_WIDTH:  cfg_q.width       <= cfg_data_i[d2p_pkg::DIM_W-1:0];
        d2p_pkg::REG_HEIGHT: cfg_q.height      <= cfg_data_i[d2p_pkg::DIM_W-1:0];
        d2p_pkg::REG_CX:     cfg_q.center_x    <= cfg_data_i[d2p_pkg::CTR_W-1:0];
        d2p_pkg::REG_CY:     cfg_q.center_y    <= cfg_data_i[d2p_pkg::CTR_W-1:0];
        d2p_pkg::REG_IFX:    cfg_q.inv_focal_x <= cfg_data_i[d2p_pkg::INVF_W-1:0];
        d2p_pkg::REG_IFY:    cfg_q.inv_focal_y <= cfg_data_i[d2p_pkg::INVF_W-1:0];
        default:             cfg_q             <= cfg_q;
      endcase
    end
  end

  // Front: raster position, grid test, last-point flag
  d2p_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .geo_start_i      (geo_start),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .depth_i          (depth_i),
    .first_of_frame_i (first_of_frame_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .push_item_o      (push_item)
  );

  // Only kept pixels enter the queue
  d2p_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_valid_o (q_valid),
    .pop_item_o  (pop_item)
  );

  // Back: projection pipeline and output register
  d2p_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (q_valid),
    .item_i        (pop_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .x_pos_o       (x_pos_o),
    .y_pos_o       (y_pos_o),
    .z_depth_o     (z_depth_o),
    .point_valid_o (point_valid_o),
    .last_point_o  (last_point_o)
  );

  // Geometry write must hold off pixels while the limits are recomputed
  `D2P_ASSERT_IMPL(a_geo_stall, clk_i, rst_ni, geo_start |=> !in_ready_o, "pixel taken during limit update")
  // Invalid depth gives an all-zero point
  `D2P_ASSERT_NEVER(a_invalid_zero, clk_i, rst_ni, out_valid_o && !point_valid_o && (x_pos_o != '0 || y_pos_o != '0 || z_depth_o != '0), "invalid point not zeroed")
  // A valid point never carries a reserved depth code
  `D2P_ASSERT_NEVER(a_valid_depth, clk_i, rst_ni, out_valid_o && point_valid_o && (z_depth_o == '0 || z_depth_o == d2p_pkg::DEPTH_BAD_HI), "valid point with reserved depth")

endmodule

>>> src/d2p_front.sv
// Front end: raster counters, decimation grid test and grid limit unit.
// Depends on d2p_pkg.
module d2p_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  d2p_pkg::cfg_t                cfg_i,
  input  logic                         geo_start_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [d2p_pkg::DEPTH_W-1:0]  depth_i,
  input  logic                         first_of_frame_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output d2p_pkg::item_t               push_item_o
);

  localparam logic [d2p_pkg::PHASE_W-1:0] BIT_TOP = d2p_pkg::PHASE_W'(d2p_pkg::DIM_W - 1);

  logic [d2p_pkg::STEP_W-1:0]  step;
  logic [d2p_pkg::DIM_W-1:0]   w_eff, h_eff;

  logic                        busy_q;
  logic [d2p_pkg::PHASE_W-1:0] bit_q;
  logic [d2p_pkg::PHASE_W-1:0] rem_w_q, rem_h_q, rem_w_d, rem_h_d;
  logic [d2p_pkg::STEP_W-1:0]  trial_w, trial_h;
  logic [d2p_pkg::DIM_W-1:0]   lim_w_q, lim_h_q, last_c_q, last_r_q;

  logic [d2p_pkg::POS_W-1:0]   cc_q, rc_q, cc_d, rc_d, cc0, rc0, cc1, rc1;
  logic [d2p_pkg::PHASE_W-1:0] cph_q, rph_q, cph_d, rph_d, cph0, rph0, cph1, rph1;
  logic [d2p_pkg::DIM_W-1:0]   cc_inc, rc_inc;
  logic [d2p_pkg::STEP_W-1:0]  cph_inc, rph_inc;
  logic                        keep, accept;

  // Clamp the geometry registers to their legal ranges
  always_comb begin
    step = cfg_i.step;
    if (step == '0) step = d2p_pkg::STEP_W'(1);
    else if (step > d2p_pkg::STEP_W'(d2p_pkg::MAX_STEP)) step = d2p_pkg::STEP_W'(d2p_pkg::MAX_STEP);
    w_eff = cfg_i.width;
    if (w_eff == '0) w_eff = d2p_pkg::DIM_W'(1);
    else if (w_eff > d2p_pkg::DIM_W'(d2p_pkg::MAX_DIMENSION))
      w_eff = d2p_pkg::DIM_W'(d2p_pkg::MAX_DIMENSION);
    h_eff = cfg_i.height;
    if (h_eff == '0) h_eff = d2p_pkg::DIM_W'(1);
    else if (h_eff > d2p_pkg::DIM_W'(d2p_pkg::MAX_DIMENSION))
      h_eff = d2p_pkg::DIM_W'(d2p_pkg::MAX_DIMENSION);
  end

  // Restoring remainder, one size bit per cycle: size mod step
  always_comb begin
    trial_w = {rem_w_q, w_eff[bit_q]};
    trial_h = {rem_h_q, h_eff[bit_q]};
    rem_w_d = (trial_w >= step) ? d2p_pkg::PHASE_W'(trial_w - step) : trial_w[d2p_pkg::PHASE_W-1:0];
    rem_h_d = (trial_h >= step) ? d2p_pkg::PHASE_W'(trial_h - step) : trial_h[d2p_pkg::PHASE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      bit_q   <= BIT_TOP;
      rem_w_q <= '0;
      rem_h_q <= '0;
    end else if (geo_start_i) begin
      busy_q  <= 1'b1;
      bit_q   <= BIT_TOP;
      rem_w_q <= '0;
      rem_h_q <= '0;
    end else if (busy_q) begin
      rem_w_q <= rem_w_d;
      rem_h_q <= rem_h_d;
      if (bit_q == '0) busy_q <= 1'b0;
      else bit_q <= bit_q - 1'b1;
    end
  end

  // Grid end and last grid position, taken on the final remainder step
  always_ff @(posedge clk_i) begin
    if (busy_q && !geo_start_i && bit_q == '0) begin
      lim_w_q  <= w_eff - d2p_pkg::DIM_W'(rem_w_d);
      lim_h_q  <= h_eff - d2p_pkg::DIM_W'(rem_h_d);
      last_c_q <= w_eff - d2p_pkg::DIM_W'(rem_w_d) - d2p_pkg::DIM_W'(step);
      last_r_q <= h_eff - d2p_pkg::DIM_W'(rem_h_d) - d2p_pkg::DIM_W'(step);
    end
  end

  assign in_ready_o = !busy_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Raster position of this pixel and next position
  always_comb begin
    cc0  = first_of_frame_i ? '0 : cc_q;
    rc0  = first_of_frame_i ? '0 : rc_q;
    cph0 = first_of_frame_i ? '0 : cph_q;
    rph0 = first_of_frame_i ? '0 : rph_q;
    cc1  = cc0;  cph1 = cph0;
    rc1  = rc0;  rph1 = rph0;
    if (d2p_pkg::DIM_W'(cc0) >= w_eff) begin
      cc1  = '0;
      cph1 = '0;
    end
    if (d2p_pkg::DIM_W'(rc0) >= h_eff) begin
      rc1  = '0;
      rph1 = '0;
    end

    keep = (cph1 == '0) && (rph1 == '0) &&
           (d2p_pkg::DIM_W'(cc1) < lim_w_q) && (d2p_pkg::DIM_W'(rc1) < lim_h_q);

    push_item_o.col   = cc1;
    push_item_o.row   = rc1;
    push_item_o.depth = depth_i;
    push_item_o.last  = (d2p_pkg::DIM_W'(cc1) == last_c_q) &&
                        (d2p_pkg::DIM_W'(rc1) == last_r_q);

    cc_inc  = d2p_pkg::DIM_W'(cc1) + 1'b1;
    rc_inc  = d2p_pkg::DIM_W'(rc1) + 1'b1;
    cph_inc = d2p_pkg::STEP_W'(cph1) + 1'b1;
    rph_inc = d2p_pkg::STEP_W'(rph1) + 1'b1;
    cc_d  = cc_inc[d2p_pkg::POS_W-1:0];
    cph_d = (cph_inc >= step) ? '0 : cph_inc[d2p_pkg::PHASE_W-1:0];
    rc_d  = rc1;
    rph_d = rph1;
    if (cc_inc >= w_eff) begin
      cc_d  = '0;
      cph_d = '0;
      rc_d  = rc_inc[d2p_pkg::POS_W-1:0];
      rph_d = (rph_inc >= step) ? '0 : rph_inc[d2p_pkg::PHASE_W-1:0];
      if (rc_inc >= h_eff) begin
        rc_d  = '0;
        rph_d = '0;
      end
    end
  end

  assign push_o = accept && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q  <= '0;
      rc_q  <= '0;
      cph_q <= '0;
      rph_q <= '0;
    end else if (accept) begin
      cc_q  <= cc_d;
      rc_q  <= rc_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
    end
  end

endmodule

>>> src/d2p_queue.sv
// Short first-in first-out queue between front and back end.
// Depends on d2p_pkg.
module d2p_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  d2p_pkg::item_t  push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            pop_valid_o,
  output d2p_pkg::item_t  pop_item_o
);

  d2p_pkg::item_t                 slot_q [d2p_pkg::QDEPTH];
  logic [d2p_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [d2p_pkg::QCNT_W-1:0]     cnt_q;
  logic                           do_pop;

  assign full_o      = cnt_q == d2p_pkg::QCNT_W'(d2p_pkg::QDEPTH);
  assign pop_valid_o = cnt_q != '0;
  assign pop_item_o  = slot_q[rd_q];
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> src/d2p_back.sv
// Back end: four-stage projection pipeline ending in the output register.
// Depends on d2p_pkg.
module d2p_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  d2p_pkg::cfg_t                 cfg_i,
  input  logic                          item_valid_i,
  input  d2p_pkg::item_t                item_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [d2p_pkg::COORD_W-1:0] x_pos_o,
  output logic signed [d2p_pkg::COORD_W-1:0] y_pos_o,
  output logic [d2p_pkg::DEPTH_W-1:0]   z_depth_o,
  output logic                          point_valid_o,
  output logic                          last_point_o
);

  localparam int unsigned P1_W = 2 * d2p_pkg::DEPTH_W;
  localparam int unsigned P2_W = P1_W + d2p_pkg::INVF_W;
  localparam int unsigned Q_W  = P2_W - d2p_pkg::INVF_W + 1;
  localparam logic [Q_W-1:0] POS_MAX = Q_W'(33'h0_7FFF_FFFF);
  localparam logic [Q_W-1:0] NEG_MAX = Q_W'(33'h0_8000_0000);
  localparam logic [P2_W:0]  HALF    = (P2_W+1)'(1) << (d2p_pkg::INVF_W - 1);

  logic adv;

  // stage 1: offset from principal point
  logic                       s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic [d2p_pkg::DEPTH_W-1:0] s1_mx_q, s1_my_q, s1_z_q, s2_z_q, s3_z_q;
  logic                       s1_nx_q, s1_ny_q, s2_nx_q, s2_ny_q, s3_nx_q, s3_ny_q;
  logic                       s1_pv_q, s2_pv_q, s3_pv_q, s1_l_q, s2_l_q, s3_l_q;
  logic signed [d2p_pkg::DEPTH_W:0] dx, dy;
  logic [d2p_pkg::DEPTH_W:0]  ndx, ndy;
  logic                       pv;

  // stages 2 and 3: products
  logic [P1_W-1:0]            s2_px_q, s2_py_q;
  logic [P2_W-1:0]            s3_px_q, s3_py_q;

  // stage 4: rounding and saturation
  logic [P2_W:0]              rx, ry;
  logic [Q_W-1:0]             qx, qy;
  logic [d2p_pkg::COORD_W-1:0] sx, sy;

  assign adv   = !out_v_q || out_ready_i;
  assign pop_o = adv;

  always_comb begin
    dx  = $signed({1'b0, item_i.col, 4'b0000}) - $signed({1'b0, cfg_i.center_x});
    dy  = $signed({1'b0, item_i.row, 4'b0000}) - $signed({1'b0, cfg_i.center_y});
    ndx = -dx;
    ndy = -dy;
    pv  = (item_i.depth != '0) && (item_i.depth != d2p_pkg::DEPTH_BAD_HI);
  end

  always_comb begin
    rx = {1'b0, s3_px_q} + HALF;
    ry = {1'b0, s3_py_q} + HALF;
    qx = rx[P2_W:d2p_pkg::INVF_W];
    qy = ry[P2_W:d2p_pkg::INVF_W];
    if (s3_nx_q) sx = (qx > NEG_MAX) ? NEG_MAX[d2p_pkg::COORD_W-1:0] : -qx[d2p_pkg::COORD_W-1:0];
    else         sx = (qx > POS_MAX) ? POS_MAX[d2p_pkg::COORD_W-1:0] : qx[d2p_pkg::COORD_W-1:0];
    if (s3_ny_q) sy = (qy > NEG_MAX) ? NEG_MAX[d2p_pkg::COORD_W-1:0] : -qy[d2p_pkg::COORD_W-1:0];
    else         sy = (qy > POS_MAX) ? POS_MAX[d2p_pkg::COORD_W-1:0] : qy[d2p_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= item_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_nx_q <= dx[d2p_pkg::DEPTH_W];
      s1_ny_q <= dy[d2p_pkg::DEPTH_W];
      s1_mx_q <= dx[d2p_pkg::DEPTH_W] ? ndx[d2p_pkg::DEPTH_W-1:0] : dx[d2p_pkg::DEPTH_W-1:0];
      s1_my_q <= dy[d2p_pkg::DEPTH_W] ? ndy[d2p_pkg::DEPTH_W-1:0] : dy[d2p_pkg::DEPTH_W-1:0];
      s1_z_q  <= item_i.depth;
      s1_pv_q <= pv;
      s1_l_q  <= item_i.last;

      s2_px_q <= P1_W'(s1_mx_q) * P1_W'(s1_z_q);
      s2_py_q <= P1_W'(s1_my_q) * P1_W'(s1_z_q);
      s2_nx_q <= s1_nx_q;
      s2_ny_q <= s1_ny_q;
      s2_z_q  <= s1_z_q;
      s2_pv_q <= s1_pv_q;
      s2_l_q  <= s1_l_q;

      s3_px_q <= P2_W'(s2_px_q) * P2_W'(cfg_i.inv_focal_x);
      s3_py_q <= P2_W'(s2_py_q) * P2_W'(cfg_i.inv_focal_y);
      s3_nx_q <= s2_nx_q;
      s3_ny_q <= s2_ny_q;
      s3_z_q  <= s2_z_q;
      s3_pv_q <= s2_pv_q;
      s3_l_q  <= s2_l_q;

      x_pos_o       <= s3_pv_q ? sx : '0;
      y_pos_o       <= s3_pv_q ? sy : '0;
      z_depth_o     <= s3_pv_q ? s3_z_q : '0;
      point_valid_o <= s3_pv_q;
      last_point_o  <= s3_l_q;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

>>> tb/sv/depth_to_point_deprojection_tb.sv
// Self-checking testbench of depth_to_point_deprojection: raster pixel requests in,
// deprojected point requests out, checked against an in-bench predictor.
// Depends on d2p_pkg and the block's RTL only.
module depth_to_point_deprojection_tb;
  import d2p_pkg::*;

  // Cycles without any request moving before the run is called hung.
  // Worst honest case is the long receiver hold plus settle and the
  // grid recompute, so this leaves a wide margin.
  localparam int unsigned QUIET_LIMIT   = 4000;
  // Block latency: 4-entry queue plus 4 pipe stages; round up for the drain.
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_ITEMS  = 540;
  localparam int unsigned WIDE_ITEMS    = 64;

  typedef struct {
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic [DEPTH_W-1:0]        z_depth;
    logic                      point_valid;
    logic                      last_point;
  } point_t;

  // Tracks raster position and registers, predicts the point each kept
  // pixel yields, and matches it against what comes out.
  class point_scoreboard;
    cfg_t        regs;
    int unsigned col_cnt, row_cnt, col_ph, row_ph;
    point_t      expected_points[$];
    int unsigned errors;

    function new();
      regs.step        = 5'd3;
      regs.width       = 13'd640;
      regs.height      = 13'd480;
      regs.center_x    = 16'd5120;
      regs.center_y    = 16'd3840;
      regs.inv_focal_x = 24'd27962;
      regs.inv_focal_y = 24'd27962;
      col_cnt = 0;
      row_cnt = 0;
      col_ph  = 0;
      row_ph  = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
      case (idx)
        REG_STEP:   regs.step        = data[STEP_W-1:0];
        REG_WIDTH:  regs.width       = data[DIM_W-1:0];
        REG_HEIGHT: regs.height      = data[DIM_W-1:0];
        REG_CX:     regs.center_x    = data[CTR_W-1:0];
        REG_CY:     regs.center_y    = data[CTR_W-1:0];
        REG_IFX:    regs.inv_focal_x = data[INVF_W-1:0];
        REG_IFY:    regs.inv_focal_y = data[INVF_W-1:0];
        default: ;
      endcase
    endfunction

    // 0 acts as 1, anything above the cap acts as the cap
    function int unsigned fit(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return fit(regs.width, MAX_DIMENSION) * fit(regs.height, MAX_DIMENSION);
    endfunction

    // Sign-magnitude product, round half away from zero at 2^-24, saturate.
    function logic signed [COORD_W-1:0] back_project(int unsigned pos,
                                                     logic [CTR_W-1:0] ctr,
                                                     logic [INVF_W-1:0] inv,
                                                     logic [DEPTH_W-1:0] z);
      longint            off;
      longint unsigned   mag, q;
      off = longint'(pos) * 16 - longint'(ctr);
      mag = (off < 0) ? -off : off;
      q = (mag * z * inv + (64'd1 << 23)) >> 24;
      if (off < 0) begin
        if (q > 64'd2147483648) q = 64'd2147483648;
        return -q[COORD_W-1:0];
      end
      if (q > 64'd2147483647) q = 64'd2147483647;
      return q[COORD_W-1:0];
    endfunction

    function void note_pixel(logic [DEPTH_W-1:0] depth, logic first);
      int unsigned step, w, h, gw, gh;
      point_t      p;
      step = fit(regs.step, MAX_STEP);
      w    = fit(regs.width, MAX_DIMENSION);
      h    = fit(regs.height, MAX_DIMENSION);
      gw   = w / step;
      gh   = h / step;
      if (first) begin
        col_cnt = 0;
        row_cnt = 0;
        col_ph  = 0;
        row_ph  = 0;
      end
      // sizes may have shrunk under a live position
      if (col_cnt >= w) begin
        col_cnt = 0;
        col_ph  = 0;
      end
      if (row_cnt >= h) begin
        row_cnt = 0;
        row_ph  = 0;
      end
      if (col_ph == 0 && row_ph == 0 && col_cnt < gw * step && row_cnt < gh * step) begin
        p.point_valid = (depth != '0) && (depth != DEPTH_BAD_HI);
        p.last_point  = (col_cnt == (gw - 1) * step) && (row_cnt == (gh - 1) * step);
        if (p.point_valid) begin
          p.x_pos   = back_project(col_cnt, regs.center_x, regs.inv_focal_x, depth);
          p.y_pos   = back_project(row_cnt, regs.center_y, regs.inv_focal_y, depth);
          p.z_depth = depth;
        end else begin
          p.x_pos   = '0;
          p.y_pos   = '0;
          p.z_depth = '0;
        end
        expected_points.push_back(p);
      end
      col_cnt++;
      col_ph = (col_ph + 1 >= step) ? 0 : col_ph + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        col_ph  = 0;
        row_cnt++;
        row_ph = (row_ph + 1 >= step) ? 0 : row_ph + 1;
        if (row_cnt >= h) begin
          row_cnt = 0;
          row_ph  = 0;
        end
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        $display("%0t: point with none expected: x %0d y %0d z %0d valid %0b last %0b",
                 $time, got.x_pos, got.y_pos, got.z_depth, got.point_valid,
                 got.last_point);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      if (got.x_pos !== want.x_pos) begin
        $display("%0t: x_pos expected %0d, got %0d", $time, want.x_pos, got.x_pos);
        errors++;
      end
      if (got.y_pos !== want.y_pos) begin
        $display("%0t: y_pos expected %0d, got %0d", $time, want.y_pos, got.y_pos);
        errors++;
      end
      if (got.z_depth !== want.z_depth) begin
        $display("%0t: z_depth expected %0d, got %0d", $time, want.z_depth, got.z_depth);
        errors++;
      end
      if (got.point_valid !== want.point_valid) begin
        $display("%0t: point_valid expected %0b, got %0b", $time, want.point_valid,
                 got.point_valid);
        errors++;
      end
      if (got.last_point !== want.last_point) begin
        $display("%0t: last_point expected %0b, got %0b", $time, want.last_point,
                 got.last_point);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_points.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CIDX_W-1:0]         cfg_index_i;
  logic [CDATA_W-1:0]        cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [DEPTH_W-1:0]        depth_i;
  logic                      first_of_frame_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [COORD_W-1:0] x_pos_o;
  logic signed [COORD_W-1:0] y_pos_o;
  logic [DEPTH_W-1:0]        z_depth_o;
  logic                      point_valid_o;
  logic                      last_point_o;

  depth_to_point_deprojection DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .depth_i          (depth_i),
    .first_of_frame_i (first_of_frame_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .x_pos_o          (x_pos_o),
    .y_pos_o          (y_pos_o),
    .z_depth_o        (z_depth_o),
    .point_valid_o    (point_valid_o),
    .last_point_o     (last_point_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  point_scoreboard sb = new();

  // Idle knobs; written by the stimulus process only.
  int unsigned send_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  // Long hold handshake between stimulus and receiver: the stimulus bumps
  // holds_asked, the receiver notices the difference and serves one hold.
  int unsigned holds_asked = 0;

  // ---------------------------------------------------------------------------
  // Receiver: check every point request that moves, then pick next ready.
  // Everything is sampled at the edge and driven with NBAs, so no race with
  // the DUT's own flops.
  // ---------------------------------------------------------------------------
  int unsigned holds_served = 0;
  int unsigned hold_left    = 0;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_point('{x_pos_o, y_pos_o, z_depth_o, point_valid_o, last_point_o});
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (holds_served != holds_asked) begin
      // back-pressure long enough for the queue to fill and in_ready_o to drop
      holds_served = holds_asked;
      hold_left    = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any request on any channel counts as progress.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no request moved for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One pixel request. Random gaps first (valid low), then hold valid with a
  // stable payload until it is taken. The predictor sees it at that edge.
  task automatic push_pixel(input logic [DEPTH_W-1:0] depth, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    depth_i          <= depth;
    first_of_frame_i <= first;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(depth, first);
  endtask

  // Register write; bits above the register's width carry junk, which the
  // block must drop.
  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input int unsigned value);
    int unsigned        bits;
    logic [CDATA_W-1:0] data;
    case (idx)
      REG_STEP:               bits = STEP_W;
      REG_WIDTH, REG_HEIGHT:  bits = DIM_W;
      REG_CX, REG_CY:         bits = CTR_W;
      default:                bits = INVF_W;
    endcase
    data = CDATA_W'(value) | ($urandom & ~((32'd1 << bits) - 1));
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  // Reprogram everything once the block has drained. Pixels outside the grid
  // give no point, so after the last point wait out the pipe as well.
  // Raster position is left alone, so a new setting lands mid-frame.
  task automatic configure(input int unsigned step, input int unsigned w,
                           input int unsigned h, input int unsigned cx,
                           input int unsigned cy, input int unsigned ifx,
                           input int unsigned ify);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_write(REG_STEP, step);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_CX, cx);
    cfg_write(REG_CY, cy);
    cfg_write(REG_IFX, ifx);
    cfg_write(REG_IFY, ify);
    cfg_valid_i <= 1'b0;
  endtask

  // Depth mix: plenty of both invalid codes and the valid extremes.
  function automatic logic [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(19))
      0, 1:    return '0;
      2:       return DEPTH_BAD_HI;
      3:       return 16'd1;
      4:       return 16'hFFFE;
      default: return DEPTH_W'($urandom);
    endcase
  endfunction

  // Mostly tiny frames; sometimes 0 (acts as 1) or past the cap.
  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, 12);
    if (r < 92) return 0;
    return $urandom_range(MAX_DIMENSION + 1, (1 << DIM_W) - 1);
  endfunction

  function automatic int unsigned pick_center();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  function automatic int unsigned pick_focal();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 1;
    if (r < 20) return 24'hFFFFFF;
    if (r < 60) return $urandom_range(20000, 40000);
    return $urandom_range(1, 24'hFFFFFF);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned step_v, random_sent, quota, sent, n, phase, r;

    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    depth_i          = '0;
    first_of_frame_i = 1'b0;
    out_ready_i      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // -- Directed ------------------------------------------------------------
    // Reset settings (step 3, 640x480): columns 0 and 3 are kept on row 0,
    // one good depth and one saturated-high invalid code.
    push_pixel(16'd1000, 1'b1);
    push_pixel('0, 1'b0);
    push_pixel('0, 1'b0);
    push_pixel(DEPTH_BAD_HI, 1'b0);
    push_pixel(16'd1, 1'b0);
    push_pixel(16'd2, 1'b0);

    // Rounding ties: offset 16 * depth 2^15 * 1/f 16 lands exactly on half an
    // LSB, both signs; one below the tie rounds to zero. Every pixel is a
    // point and the 2x1 frame ends on each second one.
    configure(1, 2, 1, 0, 16, 16, 16);
    push_pixel(16'd32768, 1'b1);
    push_pixel(16'd32768, 1'b0);
    push_pixel(16'd32767, 1'b0);
    push_pixel(16'd32767, 1'b0);
    push_pixel('0, 1'b0);
    push_pixel(DEPTH_BAD_HI, 1'b0);

    // Negative saturation: far principal point, largest 1/f and depth.
    configure(1, 2, 2, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    push_pixel(16'hFFFE, 1'b1);
    push_pixel(16'hFFFE, 1'b0);
    push_pixel(16'hFFFE, 1'b0);
    push_pixel(16'hFFFE, 1'b0);
    push_pixel(16'd1, 1'b0);
    push_pixel(16'd1, 1'b0);

    // Zero step and sizes act as 1: a 1x1 grid, every pixel is the last.
    configure(0, 0, 0, 100, 200, 30000, 30000);
    push_pixel(16'd500, 1'b1);
    push_pixel('0, 1'b0);
    push_pixel(DEPTH_BAD_HI, 1'b0);

    // Step over the cap (acts as 16) on a 3x3 image: empty grid, no points.
    configure(20, 3, 3, 0, 0, 1, 1);
    push_pixel(16'd700, 1'b1);
    push_pixel(16'd701, 1'b0);
    push_pixel(16'd702, 1'b0);
    push_pixel(16'd703, 1'b0);

    // -- Back-pressure -------------------------------------------------------
    // Receiver holds off for a long stretch while pixels keep coming at full
    // rate; the queue fills and in_ready_o has to drop.
    configure(1, 4, 4, 32, 32, 27962, 27962);
    send_idle_pct = 0;
    out_stall_pct = 0;
    holds_asked++;
    for (int i = 0; i < 48; i++)
      push_pixel(pick_depth(), (i % 16) == 0);

    // -- Wide row ------------------------------------------------------------
    // 4096 columns, step 16: the start of row 0 gives grid points every 16
    // columns; the principal point sits far below, so y saturates low for large depths.
    // The frame is left open, so the next settings land mid-row.
    configure(16, MAX_DIMENSION, 16, 0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    out_stall_pct = 6;
    for (int i = 0; i < WIDE_ITEMS; i++)
      push_pixel(($urandom_range(3) == 0) ? 16'hFFFE : pick_depth(), i == 0);

    // -- Random phases -------------------------------------------------------
    // Each phase: fresh settings, one idle mode, then mostly whole frames
    // with random depths; the rest are short runs with stray frame starts.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 60)      step_v = $urandom_range(1, 3);
      else if (r < 80) step_v = $urandom_range(4, MAX_STEP);
      else if (r < 88) step_v = 0;
      else             step_v = $urandom_range(MAX_STEP + 1, (1 << STEP_W) - 1);
      configure(step_v, pick_size(), pick_size(), pick_center(), pick_center(),
                pick_focal(), pick_focal());
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 88;
          out_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          out_stall_pct = 88;
        end
        default: begin
          send_idle_pct = 6;
          out_stall_pct = 6;
        end
      endcase
      quota = $urandom_range(40, 90);
      sent  = 0;
      while (sent < quota) begin
        if ($urandom_range(99) < 70 && sb.frame_pixels() <= 256) begin
          n = sb.frame_pixels();
          for (int i = 0; i < n; i++)
            push_pixel(pick_depth(), i == 0);
        end else begin
          n = $urandom_range(1, 24);
          for (int i = 0; i < n; i++)
            push_pixel(pick_depth(), $urandom_range(15) == 0);
        end
        sent += n;
      end
      random_sent += sent;
      phase++;
    end

    // -- Drain ---------------------------------------------------------------
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    out_stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    // any stray point would show up in this window
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> depth_to_point_deprojection.f
+incdir+src
src/d2p_pkg.sv
src/d2p_front.sv
src/d2p_queue.sv
src/d2p_back.sv
src/depth_to_point_deprojection.sv
tb/sv/depth_to_point_deprojection_tb.sv
